// ----- rtl/tgr_pkg.sv -----
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared types, constants and the 5x7 font table of the glyph rasterizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;

	localparam logic [7:0] CODE_FIRST   = 8'd32;
	localparam logic [7:0] CODE_LAST    = 8'd122;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;

	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int ADVANCE_MUL = 6;
	localparam int LINE_MUL    = 8;

	localparam logic [7:0] REG_TEXT_COLOR = 8'd0;
	localparam logic [7:0] REG_TEXT_SCALE = 8'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic glyph_in;
		logic other_in;
		logic step_ok;
		logic last_dot;
		logic finish_ok;
	} status_t;

	// Column 0 sits in the top byte, column 4 in the bottom byte.
	function automatic logic [39:0] glyph_bits(input logic [6:0] idx);
		logic [39:0] g;
		case (idx)
			7'd0:  g = 40'h00_00_00_00_00;
			7'd1:  g = 40'h00_00_5F_00_00;
			7'd2:  g = 40'h00_07_00_07_00;
			7'd3:  g = 40'h14_7F_14_7F_14;
			7'd4:  g = 40'h24_2A_7F_2A_12;
			7'd5:  g = 40'h23_13_08_64_62;
			7'd6:  g = 40'h36_49_55_22_50;
			7'd7:  g = 40'h00_05_03_00_00;
			7'd8:  g = 40'h00_1C_22_41_00;
			7'd9:  g = 40'h00_41_22_1C_00;
			7'd10: g = 40'h14_08_3E_08_14;
			7'd11: g = 40'h08_08_3E_08_08;
			7'd12: g = 40'h00_50_30_00_00;
			7'd13: g = 40'h08_08_08_08_08;
			7'd14: g = 40'h00_60_60_00_00;
			7'd15: g = 40'h20_10_08_04_02;
			7'd16: g = 40'h3E_51_49_45_3E;
			7'd17: g = 40'h00_42_7F_40_00;
			7'd18: g = 40'h42_61_51_49_46;
			7'd19: g = 40'h21_41_45_4B_31;
			7'd20: g = 40'h18_14_12_7F_10;
			7'd21: g = 40'h27_45_45_45_39;
			7'd22: g = 40'h3C_4A_49_49_30;
			7'd23: g = 40'h01_71_09_05_03;
			7'd24: g = 40'h36_49_49_49_36;
			7'd25: g = 40'h06_49_49_29_1E;
			7'd26: g = 40'h00_36_36_00_00;
			7'd27: g = 40'h00_56_36_00_00;
			7'd28: g = 40'h08_14_22_41_00;
			7'd29: g = 40'h14_14_14_14_14;
			7'd30: g = 40'h00_41_22_14_08;
			7'd31: g = 40'h02_01_51_09_06;
			7'd32: g = 40'h32_49_79_41_3E;
			7'd33: g = 40'h7E_11_11_11_7E;
			7'd34: g = 40'h7F_49_49_49_36;
			7'd35: g = 40'h3E_41_41_41_22;
			7'd36: g = 40'h7F_41_41_22_1C;
			7'd37: g = 40'h7F_49_49_49_41;
			7'd38: g = 40'h7F_09_09_09_01;
			7'd39: g = 40'h3E_41_49_49_7A;
			7'd40: g = 40'h7F_08_08_08_7F;
			7'd41: g = 40'h00_41_7F_41_00;
			7'd42: g = 40'h20_40_41_3F_01;
			7'd43: g = 40'h7F_08_14_22_41;
			7'd44: g = 40'h7F_40_40_40_40;
			7'd45: g = 40'h7F_02_0C_02_7F;
			7'd46: g = 40'h7F_04_08_10_7F;
			7'd47: g = 40'h3E_41_41_41_3E;
			7'd48: g = 40'h7F_09_09_09_06;
			7'd49: g = 40'h3E_41_51_21_5E;
			7'd50: g = 40'h7F_09_19_29_46;
			7'd51: g = 40'h46_49_49_49_31;
			7'd52: g = 40'h01_01_7F_01_01;
			7'd53: g = 40'h3F_40_40_40_3F;
			7'd54: g = 40'h1F_20_40_20_1F;
			7'd55: g = 40'h3F_40_38_40_3F;
			7'd56: g = 40'h63_14_08_14_63;
			7'd57: g = 40'h07_08_70_08_07;
			7'd58: g = 40'h61_51_49_45_43;
			7'd59: g = 40'h00_7F_41_41_00;
			7'd60: g = 40'h02_04_08_10_20;
			7'd61: g = 40'h00_41_41_7F_00;
			7'd62: g = 40'h04_02_01_02_04;
			7'd63: g = 40'h40_40_40_40_40;
			7'd64: g = 40'h00_01_02_04_00;
			7'd65: g = 40'h20_54_54_54_78;
			7'd66: g = 40'h7F_48_44_44_38;
			7'd67: g = 40'h38_44_44_44_20;
			7'd68: g = 40'h38_44_44_48_7F;
			7'd69: g = 40'h38_54_54_54_18;
			7'd70: g = 40'h08_7E_09_01_02;
			7'd71: g = 40'h0C_52_52_52_3E;
			7'd72: g = 40'h7F_08_04_04_78;
			7'd73: g = 40'h00_44_7D_40_00;
			7'd74: g = 40'h20_40_44_3D_00;
			7'd75: g = 40'h7F_10_28_44_00;
			7'd76: g = 40'h00_41_7F_40_00;
			7'd77: g = 40'h7C_04_18_04_78;
			7'd78: g = 40'h7C_08_04_04_78;
			7'd79: g = 40'h38_44_44_44_38;
			7'd80: g = 40'h7C_14_14_14_08;
			7'd81: g = 40'h08_14_14_18_7C;
			7'd82: g = 40'h7C_08_04_04_08;
			7'd83: g = 40'h48_54_54_54_20;
			7'd84: g = 40'h04_3F_44_40_20;
			7'd85: g = 40'h3C_40_40_40_7C;
			7'd86: g = 40'h1C_20_40_20_1C;
			7'd87: g = 40'h3C_40_30_40_3C;
			7'd88: g = 40'h44_28_10_28_44;
			7'd89: g = 40'h0C_50_50_50_3C;
			7'd90: g = 40'h44_64_54_4C_44;
			default: g = 40'h00_00_00_00_00;
		endcase
		return g;
	endfunction

endpackage

// ----- rtl/tgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// tgr_ctrl
// Sequencer of the glyph rasterizer: accept, dot scan and cursor finish.
// ----------------------------------------------------------------------------
module tgr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tgr_pkg::status_t status,
	output tgr_pkg::cmd_t    cmd
);
	import tgr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (status.glyph_in) begin
						state_d = ST_SCAN;
					end else if (status.other_in) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				if (status.step_ok && status.last_dot) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.finish_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCAN:   cmd.scan   = 1'b1;
			ST_FINISH: cmd.finish = 1'b1;
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_scan_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && status.step_ok && status.last_dot) |=> state_q == ST_FINISH)
		else $error("scan did not end in finish");
`endif

endmodule

// ----- rtl/tgr_datapath.sv -----
// ----------------------------------------------------------------------------
// tgr_datapath
// Cursor, configuration, dot counters, pending square and output register.
// ----------------------------------------------------------------------------
module tgr_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  tgr_pkg::cmd_t      cmd,
	output tgr_pkg::status_t   status,
	input  logic               cfg_valid,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               command,
	input  logic [7:0]         char_code,
	input  logic signed [15:0] new_x,
	input  logic signed [15:0] new_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] rect_x,
	output logic signed [15:0] rect_y,
	output logic [7:0]         rect_side,
	output logic [15:0]        rect_color,
	output logic               last_of_char
);
	import tgr_pkg::*;

	logic [15:0] cursor_x_q, cursor_y_q, color_q;
	logic [7:0]  scale_q, code_q;
	logic [2:0]  col_q, row_q;
	logic [10:0] col_off_q, row_off_q;
	logic        pend_valid_q;
	logic [15:0] pend_x_q, pend_y_q;
	logic        out_valid_q, out_last_q;
	logic [15:0] out_x_q, out_y_q;

	logic [39:0] glyph_w;
	logic [7:0]  col_bits;
	logic [15:0] px, py, cx_adv, y_line;
	logic [10:0] adv_step;
	logic        lit, keep_pos, kept, out_free, push_scan, push_fin, is_newline;

	assign glyph_w = glyph_bits(7'(code_q - CODE_FIRST));

	always_comb begin
		case (col_q)
			3'd0:    col_bits = glyph_w[39:32];
			3'd1:    col_bits = glyph_w[31:24];
			3'd2:    col_bits = glyph_w[23:16];
			3'd3:    col_bits = glyph_w[15:8];
			3'd4:    col_bits = glyph_w[7:0];
			default: col_bits = 8'h00;
		endcase
	end

	assign lit = col_bits[row_q];
	assign px  = cursor_x_q + {5'b0, col_off_q};
	assign py  = cursor_y_q + {5'b0, row_off_q};

	always_comb begin
		if (scale_q == 8'd1) begin
			keep_pos = !px[15] && !py[15] &&
				($signed(px) < $signed(16'(SCREEN_WIDTH))) &&
				($signed(py) < $signed(16'(SCREEN_HEIGHT)));
		end else begin
			keep_pos = ($signed(px) < $signed(16'(SCREEN_WIDTH))) &&
				($signed(py) < $signed(16'(SCREEN_HEIGHT)));
		end
	end

	assign kept     = lit && keep_pos;
	assign out_free = !out_valid_q || out_ready;

	assign status.glyph_in  = !command && (char_code >= CODE_FIRST) && (char_code <= CODE_LAST);
	assign is_newline       = char_code == CODE_NEWLINE;
	assign status.other_in  = !command && !is_newline && !status.glyph_in;
	assign status.step_ok   = !(kept && pend_valid_q && !out_free);
	assign status.last_dot  = (col_q == 3'(GLYPH_COLS - 1)) && (row_q == 3'(GLYPH_ROWS - 1));
	assign status.finish_ok = !pend_valid_q || out_free;

	assign push_scan = cmd.scan && kept && pend_valid_q && out_free;
	assign push_fin  = cmd.finish && pend_valid_q && out_free;

	assign adv_step = 11'(scale_q) * 11'(ADVANCE_MUL);
	assign cx_adv   = cursor_x_q + {5'b0, adv_step};
	assign y_line   = cursor_y_q + 16'(11'(scale_q) * 11'(LINE_MUL));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q      <= 16'hFFFF;
			scale_q      <= 8'd1;
			cursor_x_q   <= 16'd0;
			cursor_y_q   <= 16'd0;
			col_q        <= 3'd0;
			row_q        <= 3'd0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_TEXT_COLOR) begin
					color_q <= cfg_data;
				end else if (cfg_index == REG_TEXT_SCALE) begin
					scale_q <= (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
				end
			end

			if (cmd.load) begin
				col_q <= 3'd0;
				row_q <= 3'd0;
				if (command) begin
					cursor_x_q <= new_x;
					cursor_y_q <= new_y;
				end else if (is_newline) begin
					cursor_x_q <= 16'd0;
					cursor_y_q <= y_line;
				end
			end

			if (cmd.scan && status.step_ok) begin
				if (row_q == 3'(GLYPH_ROWS - 1)) begin
					row_q <= 3'd0;
					col_q <= col_q + 3'd1;
				end else begin
					row_q <= row_q + 3'd1;
				end
				if (kept) begin
					pend_valid_q <= 1'b1;
				end
			end

			if (cmd.finish && status.finish_ok) begin
				pend_valid_q <= 1'b0;
				if ($signed(cx_adv) > $signed(16'(SCREEN_WIDTH - ADVANCE_MUL))) begin
					cursor_x_q <= 16'd0;
					cursor_y_q <= y_line;
				end else begin
					cursor_x_q <= cx_adv;
				end
			end

			if (push_scan || push_fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q    <= char_code;
			col_off_q <= 11'd0;
			row_off_q <= 11'd0;
		end
		if (cmd.scan && status.step_ok) begin
			if (row_q == 3'(GLYPH_ROWS - 1)) begin
				row_off_q <= 11'd0;
				col_off_q <= col_off_q + 11'(scale_q);
			end else begin
				row_off_q <= row_off_q + 11'(scale_q);
			end
			if (kept) begin
				pend_x_q <= px;
				pend_y_q <= py;
			end
		end
		if (push_scan || push_fin) begin
			out_x_q    <= pend_x_q;
			out_y_q    <= pend_y_q;
			out_last_q <= push_fin;
		end
	end

	assign out_valid    = out_valid_q;
	assign rect_x       = out_x_q;
	assign rect_y       = out_y_q;
	assign rect_side    = scale_q;
	assign rect_color   = color_q;
	assign last_of_char = out_last_q;

`ifndef NO_ASSERTIONS
	a_pend_empty_at_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !pend_valid_q)
		else $error("pending square left over at accept");
	a_counter_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= 3'(GLYPH_COLS)) && (row_q < 3'(GLYPH_ROWS)))
		else $error("dot counters out of range");
	a_scale_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q != 8'd0)
		else $error("scale register holds zero");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(push_scan || push_fin))
		else $error("output register overwritten while stalled");
`endif

endmodule

// ----- rtl/text_glyph_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// text_glyph_rasterizer_unit
// Scaled 5x7 character generator with a signed 16-bit text cursor.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready: a print command with a character
// code, or a set-cursor command with new_x and new_y. Each lit, unclipped dot
// of a printable glyph leaves as one square on out_valid/out_ready, and the
// final square of a character carries last_of_char. The configuration channel
// cfg_valid/cfg_ready takes color and scale writes, with cfg_ready always high.
// A set-cursor command and a newline finish in the accept cycle. A code
// without a glyph goes from the accept to the finish state, which moves the
// cursor. A printable glyph goes from the accept to the dot scan, in which
// the sequencer visits each of the 5x7 font dots in turn, and then to the
// finish state, which drains the held square and moves the cursor.
// A square appears on the cycle after the next kept dot of its glyph is
// scanned, and the final one on the cycle after the cursor update, since one
// square is held back to learn whether it is the last.
// When the receiver stalls, the output register holds its transfer and the
// dot scan pauses at a kept dot while another square is still held back.
// Reset clears the cursor to zero, sets the color to white and the scale to
// one, and empties the output.
// ----------------------------------------------------------------------------
module text_glyph_rasterizer_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [7:0]         char_code,
	input  logic signed [15:0] new_x,
	input  logic signed [15:0] new_y,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] rect_x,
	output logic signed [15:0] rect_y,
	output logic [7:0]         rect_side,
	output logic [15:0]        rect_color,
	output logic               last_of_char
);
	import tgr_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	tgr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.char_code    (char_code),
		.new_x        (new_x),
		.new_y        (new_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_side    (rect_side),
		.rect_color   (rect_color),
		.last_of_char (last_of_char)
	);

endmodule

// ----- tb/sv/text_glyph_rasterizer_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_glyph_rasterizer_unit_test
// Self-checking bench for the scaled 5x7 character generator.
// ----------------------------------------------------------------------------
// A queue of print and set-cursor commands feeds a driver that idles at
// random between transfers. Each accepted command runs through a local model
// of the cursor, font and clipping, which queues the squares it must produce.
// A monitor stalls the output at random and compares every square transfer
// with the oldest queued square. Color and scale change only between phases,
// after all squares have arrived and the block has settled.
// ----------------------------------------------------------------------------
module text_glyph_rasterizer_unit_test;
	import tgr_pkg::*;

	localparam int SETTLE_CYCLES = 50;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 55;
	localparam logic [7:0] REG_NONE = 8'hFF;

	typedef struct {
		logic               command;
		logic [7:0]         code;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
	} text_cmd_t;

	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         side;
		logic [15:0]        color;
		logic               last_flag;
	} square_t;

	localparam logic [39:0] FONT [0:90] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
		40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
		40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
		40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
		40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
		40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
		40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
		40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
		40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
		40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
		40'h3C4040407C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
		40'h4464544C44
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               command = 1'b0;
	logic [7:0]         char_code = 8'd0;
	logic signed [15:0] new_x = 16'sd0;
	logic signed [15:0] new_y = 16'sd0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [7:0]         cfg_index = 8'd0;
	logic [15:0]        cfg_data = 16'd0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [15:0] rect_x;
	logic signed [15:0] rect_y;
	logic [7:0]         rect_side;
	logic [15:0]        rect_color;
	logic               last_of_char;

	text_glyph_rasterizer_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.char_code    (char_code),
		.new_x        (new_x),
		.new_y        (new_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_side    (rect_side),
		.rect_color   (rect_color),
		.last_of_char (last_of_char)
	);

	text_cmd_t          cmd_q[$];
	square_t            squares_due[$];
	logic signed [15:0] cur_x = 16'sd0;
	logic signed [15:0] cur_y = 16'sd0;
	logic [15:0]        ink = 16'hFFFF;
	logic [7:0]         zoom = 8'd1;
	int                 in_max = 14;
	int                 out_max = 14;
	int                 in_gap = 0;
	int                 out_stall = 0;
	logic               in_taken = 1'b0;
	logic               cfg_seen = 1'b0;
	int                 err_count = 0;
	text_cmd_t          launch;
	square_t            want;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	task automatic advance_line();
		cur_x = 16'sd0;
		cur_y = cur_y + 16'(LINE_MUL * zoom);
	endtask

	task automatic rasterize(input text_cmd_t c);
		square_t            sq;
		square_t            glyph[$];
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [39:0]        bits;
		logic               keep;
		if (c.command) begin
			cur_x = c.nx;
			cur_y = c.ny;
			return;
		end
		if (c.code == CODE_NEWLINE) begin
			advance_line();
			return;
		end
		if (c.code >= CODE_FIRST && c.code <= CODE_LAST) begin
			bits = FONT[c.code - CODE_FIRST];
			for (int col = 0; col < GLYPH_COLS; col++) begin
				for (int row = 0; row < GLYPH_ROWS; row++) begin
					if (bits[32 - 8 * col + row]) begin
						px = cur_x + 16'(col * zoom);
						py = cur_y + 16'(row * zoom);
						if (zoom == 8'd1)
							keep = px >= 0 && px < SCREEN_WIDTH && py >= 0 && py < SCREEN_HEIGHT;
						else
							keep = px < SCREEN_WIDTH && py < SCREEN_HEIGHT;
						if (keep) begin
							sq.x = px;
							sq.y = py;
							sq.side = zoom;
							sq.color = ink;
							sq.last_flag = 1'b0;
							glyph.push_back(sq);
						end
					end
				end
			end
			if (glyph.size() > 0)
				glyph[glyph.size() - 1].last_flag = 1'b1;
			foreach (glyph[i])
				squares_due.push_back(glyph[i]);
		end
		cur_x = cur_x + 16'(ADVANCE_MUL * zoom);
		if (cur_x > SCREEN_WIDTH - ADVANCE_MUL)
			advance_line();
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			rasterize('{command, char_code, new_x, new_y});
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
		end else if (in_gap > 0) begin
			in_taken = 1'b0;
			in_valid <= 1'b0;
			in_gap--;
		end else if (cmd_q.size() > 0) begin
			in_taken = 1'b0;
			launch = cmd_q.pop_front();
			in_valid <= 1'b1;
			command <= launch.command;
			char_code <= launch.code;
			new_x <= launch.nx;
			new_y <= launch.ny;
			in_gap = $urandom_range(0, in_max);
		end else begin
			in_taken = 1'b0;
			in_valid <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEXT_COLOR: begin
					ink = cfg_data;
				end
				REG_TEXT_SCALE: begin
					zoom = (cfg_data[7:0] == 8'd0) ? 8'd1 : cfg_data[7:0];
				end
				default: begin
				end
			endcase
			cfg_seen = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (squares_due.size() == 0) begin
				err_count++;
				$display("%0t: square at x %0d y %0d with none expected", $time, rect_x, rect_y);
			end else begin
				want = squares_due.pop_front();
				if (rect_x !== want.x) begin
					err_count++;
					$display("%0t: rect_x expected %0d got %0d", $time, want.x, rect_x);
				end
				if (rect_y !== want.y) begin
					err_count++;
					$display("%0t: rect_y expected %0d got %0d", $time, want.y, rect_y);
				end
				if (rect_side !== want.side) begin
					err_count++;
					$display("%0t: rect_side expected %0d got %0d", $time, want.side, rect_side);
				end
				if (rect_color !== want.color) begin
					err_count++;
					$display("%0t: rect_color expected %h got %h", $time, want.color, rect_color);
				end
				if (last_of_char !== want.last_flag) begin
					err_count++;
					$display("%0t: last_of_char expected %b got %b", $time, want.last_flag,
						last_of_char);
				end
			end
			out_stall = $urandom_range(0, out_max);
		end
	end

	task automatic push_cmd(input logic cmd, input logic [7:0] code,
			input logic signed [15:0] x, input logic signed [15:0] y);
		cmd_q.push_back('{cmd, code, x, y});
	endtask

	function automatic text_cmd_t random_cmd();
		text_cmd_t c;
		int        sel;
		sel = $urandom_range(0, 99);
		c.command = 1'b0;
		c.code = 8'($urandom_range(CODE_FIRST, CODE_LAST));
		c.nx = 16'($urandom);
		c.ny = 16'($urandom);
		if (sel < 10) begin
			c.code = CODE_NEWLINE;
		end else if (sel < 18) begin
			do
				c.code = 8'($urandom_range(0, 255));
			while (c.code == CODE_NEWLINE || (c.code >= CODE_FIRST && c.code <= CODE_LAST));
		end else if (sel < 32) begin
			c.command = 1'b1;
			c.code = 8'($urandom);
			case ($urandom_range(0, 3))
				0: begin
					c.nx = 16'($urandom_range(0, SCREEN_WIDTH - 1));
					c.ny = 16'($urandom_range(0, SCREEN_HEIGHT - 1));
				end
				1: begin
					c.nx = 16'($urandom_range(SCREEN_WIDTH - 20, SCREEN_WIDTH + 10));
					c.ny = 16'($urandom_range(SCREEN_HEIGHT - 20, SCREEN_HEIGHT + 10));
				end
				2: begin
					c.nx = 16'(int'($urandom_range(0, 50)) - 40);
					c.ny = 16'(int'($urandom_range(0, 50)) - 40);
				end
				default: begin
				end
			endcase
		end
		return c;
	endfunction

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_seen = 1'b0;
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do
			@(negedge clk);
		while (!cfg_seen);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_for_squares();
		while (!(cmd_q.size() == 0 && !in_valid && squares_due.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0]  scales [0:PHASES-1];
		int          in_caps [0:PHASES-1];
		int          out_caps [0:PHASES-1];
		logic [15:0] color;
		scales = '{8'd1, 8'd2, 8'd255, 8'd0, 8'd3, 8'd128, 8'd5, 8'd1};
		in_caps = '{14, 0, 14, 0, 14, 0, 14, 14};
		out_caps = '{14, 14, 0, 0, 14, 14, 0, 14};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset color and scale, cursor at the origin.
		push_cmd(1'b0, 8'd65, 16'sh7FFF, -16'sd32768);
		push_cmd(1'b0, CODE_FIRST, 16'sd0, 16'sd0);
		push_cmd(1'b0, 8'd33, 16'sd0, 16'sd0);
		push_cmd(1'b0, CODE_LAST, 16'sd0, 16'sd0);
		push_cmd(1'b0, CODE_LAST + 8'd1, 16'sd0, 16'sd0);
		push_cmd(1'b0, CODE_FIRST - 8'd1, 16'sd0, 16'sd0);
		push_cmd(1'b0, 8'd0, 16'sd0, 16'sd0);
		push_cmd(1'b0, 8'hFF, -16'sd1, -16'sd1);
		push_cmd(1'b0, CODE_NEWLINE, 16'sd0, 16'sd0);
		push_cmd(1'b1, 8'hFF, 16'sd312, 16'sd8);
		push_cmd(1'b0, 8'd72, 16'sd0, 16'sd0);
		push_cmd(1'b1, 8'd0, -16'sd3, -16'sd2);
		push_cmd(1'b0, 8'd35, 16'sd0, 16'sd0);
		push_cmd(1'b1, 8'd0, 16'sd318, 16'sd236);
		push_cmd(1'b0, 8'd87, 16'sd0, 16'sd0);
		push_cmd(1'b1, 8'd0, 16'sh7FFF, 16'sh7FFF);
		push_cmd(1'b0, 8'd66, 16'sd0, 16'sd0);
		push_cmd(1'b1, 8'hFF, -16'sd32768, -16'sd32768);
		push_cmd(1'b0, 8'd77, 16'sd0, 16'sd0);
		push_cmd(1'b1, 8'd0, 16'sd0, 16'sd239);
		push_cmd(1'b0, 8'd95, 16'sd0, 16'sd0);
		push_cmd(1'b0, CODE_NEWLINE, 16'sd0, 16'sd0);
		push_cmd(1'b0, 8'd103, 16'sd0, 16'sd0);
		wait_for_squares();

		for (int p = 0; p < PHASES; p++) begin
			in_max = in_caps[p];
			out_max = out_caps[p];
			color = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
			write_reg(REG_TEXT_COLOR, color);
			write_reg(REG_TEXT_SCALE, {8'($urandom), scales[p]});
			if (p % 3 == 0)
				write_reg((p == 0) ? REG_NONE : 8'($urandom_range(2, 254)), 16'($urandom));
			push_cmd(1'b1, 8'($urandom), 16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					wait_for_squares();
				cmd_q.push_back(random_cmd());
			end
			wait_for_squares();
		end

		if (err_count == 0 && squares_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d squares outstanding", squares_due.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/tgr_pkg.sv
rtl/tgr_ctrl.sv
rtl/tgr_datapath.sv
rtl/text_glyph_rasterizer_unit.sv
tb/sv/text_glyph_rasterizer_unit_test.sv
